// ----- rtl/core/cache_set_lru_lfu_replace_unit_defines.svh -----
// Assertion helpers for the replacement unit.
`ifndef CACHE_SET_LRU_LFU_REPLACE_UNIT_DEFINES_SVH
`define CACHE_SET_LRU_LFU_REPLACE_UNIT_DEFINES_SVH

// same-cycle implication
`define CLF_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CLF_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/clrlfu_pkg.sv -----
package clrlfu_pkg;

	localparam int WAYS  = 4;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_DUP    = 2'd1;
	localparam logic [1:0] STATUS_NO_LFU = 2'd2;

	localparam logic POLICY_LRU = 1'b0;
	localparam logic POLICY_LFU = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [47:0] tag;
		logic [31:0] age_stamp;
		logic [31:0] use_count;
		logic        recent_flag;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  hit_way;
		logic        victim_valid;
		logic [47:0] victim_tag;
		logic [31:0] victim_stamp;
		logic [31:0] victim_count;
		logic [1:0]  status;
	} result_t;

	// running search record handed from cell to cell
	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] hit_way;
		logic             free_found;
		logic [WAY_W-1:0] free_way;
		logic             best_found;
		logic [WAY_W-1:0] best_way;
		logic [47:0]      best_tag;
		logic [31:0]      best_stamp;
		logic [31:0]      best_count;
	} srch_t;

	// write-back broadcast to all cells
	typedef struct packed {
		logic             en;
		logic             clr;
		logic [WAY_W-1:0] way;
		logic [47:0]      tag;
		logic [31:0]      stamp;
		logic [31:0]      count;
		logic             recent;
	} wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	function automatic logic [1:0] way_to_hit(input logic [WAY_W-1:0] way);
		logic [WAY_W+1:0] ext;
		ext = {2'b00, way};
		return ext[1:0];
	endfunction

endpackage

// ----- rtl/core/clrlfu_cell.sv -----
module clrlfu_cell import clrlfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WAY_W-1:0] idx,
	input  logic             policy,
	input  wr_t              wr,
	input  logic             prev_vld,
	input  item_t            prev_item,
	input  srch_t            prev_rec,
	output logic             next_vld,
	output item_t            next_item,
	output srch_t            next_rec
);

	logic        valid_q;
	logic        recent_q;
	logic [47:0] tag_q;
	logic [31:0] stamp_q;
	logic [31:0] count_q;

	logic        vld_q;
	item_t       item_q;
	srch_t       rec_q;
	srch_t       rec_d;
	logic        cand;
	logic        better;

	// way entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			recent_q <= 1'b0;
		end else if (wr.en && wr.way == idx) begin
			valid_q  <= 1'b1;
			recent_q <= wr.recent;
		end else if (wr.clr) begin
			recent_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.way == idx) begin
			tag_q   <= wr.tag;
			stamp_q <= wr.stamp;
			count_q <= wr.count;
		end
	end

	always_comb begin
		rec_d = prev_rec;
		if (!prev_rec.hit && valid_q && tag_q == prev_item.tag) begin
			rec_d.hit     = 1'b1;
			rec_d.hit_way = idx;
		end
		if (!prev_rec.free_found && !valid_q) begin
			rec_d.free_found = 1'b1;
			rec_d.free_way   = idx;
		end
		if (policy == POLICY_LRU) begin
			cand   = valid_q;
			better = !prev_rec.best_found || stamp_q < prev_rec.best_stamp;
		end else begin
			cand   = valid_q && !recent_q;
			better = !prev_rec.best_found || count_q < prev_rec.best_count ||
				(count_q == prev_rec.best_count && tag_q < prev_rec.best_tag);
		end
		if (cand && better) begin
			rec_d.best_found = 1'b1;
			rec_d.best_way   = idx;
			rec_d.best_tag   = tag_q;
			rec_d.best_stamp = stamp_q;
			rec_d.best_count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_vld) begin
			item_q <= prev_item;
			rec_q  <= rec_d;
		end
	end

	assign next_vld  = vld_q;
	assign next_item = item_q;
	assign next_rec  = rec_q;

endmodule

// ----- rtl/core/cache_set_lru_lfu_replace_unit.sv -----
// channel | signals                          | word
// --------+----------------------------------+----------
// in      | in_valid, in_stall, in_word      | item_t
// out     | out_valid, out_stall, out_word   | result_t
// cfg     | cfg_we, cfg_wdata                | policy bit
//
// A word walks the row of way cells, one way per cycle, then is written back
// from the commit state, one word at a time.
// Reset clears valid and recent marks, the policy (LRU) and all handshakes.
// A finished result waits in the output register; a new word is taken
// meanwhile, and the write-back holds only if that register is still full.
module cache_set_lru_lfu_replace_unit import clrlfu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  item_t   in_word,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_word,
	input  logic    cfg_we,
	input  logic    cfg_wdata
);

	`include "cache_set_lru_lfu_replace_unit_defines.svh"

	logic            policy_q;
	state_t          state_q;
	state_t          state_d;
	logic            accept;
	logic            commit;

	logic [WAYS:0]   chain_vld;
	item_t           chain_item [WAYS+1];
	srch_t           chain_rec  [WAYS+1];

	item_t           fin_item_q;
	srch_t           fin_rec_q;

	wr_t             wr;
	result_t         res;
	logic            out_valid_q;
	result_t         out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_LRU;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	assign accept        = in_valid && !in_stall;
	assign chain_vld[0]  = accept;
	assign chain_item[0] = in_word;
	assign chain_rec[0]  = '0;

	for (genvar i = 0; i < WAYS; i++) begin : g_cell
		clrlfu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (WAY_W'(i)),
			.policy    (policy_q),
			.wr        (wr),
			.prev_vld  (chain_vld[i]),
			.prev_item (chain_item[i]),
			.prev_rec  (chain_rec[i]),
			.next_vld  (chain_vld[i+1]),
			.next_item (chain_item[i+1]),
			.next_rec  (chain_rec[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (chain_vld[WAYS]) begin
			fin_item_q <= chain_item[WAYS];
			fin_rec_q  <= chain_rec[WAYS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (chain_vld[WAYS]) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!out_valid_q || !out_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result and write-back from the finished search record
	always_comb begin
		res       = '0;
		wr        = '0;
		wr.tag    = fin_item_q.tag;
		wr.stamp  = fin_item_q.age_stamp;
		wr.count  = fin_item_q.use_count;
		wr.recent = fin_item_q.recent_flag;
		case (fin_item_q.mode)
			MODE_LOOKUP: begin
				if (fin_rec_q.hit) begin
					res.hit     = 1'b1;
					res.hit_way = way_to_hit(fin_rec_q.hit_way);
				end
			end
			MODE_INSERT: begin
				if (fin_rec_q.hit) begin
					res.status = STATUS_DUP;
				end else if (fin_rec_q.free_found) begin
					wr.en  = commit;
					wr.way = fin_rec_q.free_way;
				end else if (fin_rec_q.best_found) begin
					wr.en             = commit;
					wr.way            = fin_rec_q.best_way;
					res.victim_valid  = 1'b1;
					res.victim_tag    = fin_rec_q.best_tag;
					res.victim_stamp  = fin_rec_q.best_stamp;
					res.victim_count  = fin_rec_q.best_count;
				end else begin
					res.status = STATUS_NO_LFU;
				end
			end
			MODE_CLEAR: begin
				wr.clr = commit;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`CLF_ASSERT_IMP(a_one_token, 1'b1, $onehot0(chain_vld), "more than one word in the cell row")
	`CLF_ASSERT_IMP(a_accept_empty, accept, chain_vld[WAYS:1] == '0 && state_q == ST_IDLE, "word taken while row busy")
	`CLF_ASSERT_IMP(a_victim_clean, out_valid && out_word.victim_valid, out_word.status == STATUS_DONE && !out_word.hit, "victim reported with hit or error")
	`CLF_ASSERT_NXT(a_commit_out, commit, out_valid_q, "write-back without result")

endmodule
